// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property violated");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== rtl/sht_pkg.sv =====
`timescale 1ns / 1ps
package sht_pkg;

  localparam int unsigned LayoutW = 31;
  localparam int unsigned MaskW   = 32;
  localparam int unsigned LayerW  = 3;
  localparam int unsigned LSpanW  = 4;
  localparam int unsigned MipW    = 4;
  localparam int unsigned MSpanW  = 5;

  // Standard access flags that count as writes.
  localparam logic [MaskW-1:0] AccShaderWrite       = 32'h0000_0040;
  localparam logic [MaskW-1:0] AccColorAttWrite     = 32'h0000_0100;
  localparam logic [MaskW-1:0] AccDepthStencilWrite = 32'h0000_0400;
  localparam logic [MaskW-1:0] AccTransferWrite     = 32'h0000_1000;
  localparam logic [MaskW-1:0] AccHostWrite         = 32'h0000_4000;
  localparam logic [MaskW-1:0] AccMemoryWrite       = 32'h0001_0000;

  localparam logic [MaskW-1:0] WriteMaskReset = AccShaderWrite | AccColorAttWrite |
                                                AccDepthStencilWrite | AccTransferWrite |
                                                AccHostWrite | AccMemoryWrite;

  // Depth of the queue between classifier and walker.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = 1;
  localparam int unsigned QCntW      = 2;

  typedef struct packed {
    logic [LayoutW-1:0] target_layout;
    logic [MaskW-1:0]   dest_stage;
    logic [MaskW-1:0]   dest_access;
    logic [LayerW-1:0]  first_layer;
    logic [LSpanW-1:0]  layer_span;
    logic [MipW-1:0]    first_mip;
    logic [MSpanW-1:0]  mip_span;
  } sht_req_t;

  typedef struct packed {
    logic               barrier_needed;
    logic [LayoutW-1:0] prior_layout;
    logic [MaskW-1:0]   prior_stage;
    logic [MaskW-1:0]   prior_access;
    logic               range_clipped;
  } sht_rsp_t;

  // Request after classification: inclusive, clipped range bounds.
  typedef struct packed {
    logic [LayoutW-1:0] target_layout;
    logic [MaskW-1:0]   dest_stage;
    logic [MaskW-1:0]   dest_access;
    logic [LayerW-1:0]  first_layer;
    logic [LayerW-1:0]  last_layer;
    logic [MipW-1:0]    first_mip;
    logic [MipW-1:0]    last_mip;
    logic               base_in;
    logic               empty;
    logic               clipped;
  } sht_cmd_t;

  typedef struct packed {
    logic [LayoutW-1:0] layout;
    logic [MaskW-1:0]   stage;
    logic [MaskW-1:0]   access;
  } sht_entry_t;

endpackage

// ===== rtl/sht_front.sv =====
`timescale 1ns / 1ps
module sht_front #(
  parameter int unsigned MAX_LAYERS = 8,
  parameter int unsigned MAX_MIPS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sht_pkg::sht_req_t in_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output sht_pkg::sht_cmd_t q_data_o
);
  import sht_pkg::*;

  // Only layers below eight can ever be addressed by a request.
  localparam int unsigned NumLayers = (MAX_LAYERS < (1 << LayerW)) ? MAX_LAYERS
                                                                   : (1 << LayerW);

  localparam logic [4:0] NumLayersV = 5'(NumLayers);
  localparam logic [5:0] MaxMipsV   = 6'(MAX_MIPS);

  logic       cls_valid_q;
  sht_cmd_t   cls_q, cls_d;
  logic       accept;
  logic [4:0] l_end, l_lim;
  logic [5:0] m_end, m_lim;
  logic       base_in, l_clip, m_clip;

  always_comb begin
    l_end   = {2'b00, in_data_i.first_layer} + {1'b0, in_data_i.layer_span};
    m_end   = {2'b00, in_data_i.first_mip} + {1'b0, in_data_i.mip_span};
    base_in = ({2'b00, in_data_i.first_layer} < NumLayersV) &&
              ({2'b00, in_data_i.first_mip} < MaxMipsV);
    // Layer end reaches 22 at most; compare it with the full layer count.
    l_clip  = {27'd0, l_end} > MAX_LAYERS;
    m_clip  = m_end > MaxMipsV;
    l_lim   = (l_end > NumLayersV) ? NumLayersV : l_end;
    m_lim   = m_clip ? MaxMipsV : m_end;

    cls_d.target_layout = in_data_i.target_layout;
    cls_d.dest_stage    = in_data_i.dest_stage;
    cls_d.dest_access   = in_data_i.dest_access;
    cls_d.first_layer   = in_data_i.first_layer;
    cls_d.first_mip     = in_data_i.first_mip;
    cls_d.last_layer    = LayerW'(l_lim - 5'd1);
    cls_d.last_mip      = MipW'(m_lim - 6'd1);
    cls_d.base_in       = base_in;
    cls_d.empty         = !base_in || (in_data_i.layer_span == '0) ||
                          (in_data_i.mip_span == '0);
    cls_d.clipped       = l_clip || m_clip || !base_in;
  end

  assign q_push_o   = cls_valid_q && !q_full_i;
  assign in_stall_o = cls_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_data_o   = cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_valid_q <= 1'b0;
    end else if (accept) begin
      cls_valid_q <= 1'b1;
    end else if (q_push_o) begin
      cls_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q <= cls_d;
    end
  end

endmodule

// ===== rtl/sht_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sht_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  sht_pkg::sht_cmd_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output sht_pkg::sht_cmd_t pop_data_o
);
  import sht_pkg::*;

  sht_cmd_t           slot_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q;

  assign full_o      = cnt_q == QCntW'(QueueDepth);
  assign pop_valid_o = cnt_q != '0;
  assign pop_data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The classifier must hold while full; the walker must not pop from nothing.
  `ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && !pop_valid_o)

endmodule

// ===== rtl/sht_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sht_back #(
  parameter int unsigned MAX_LAYERS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [sht_pkg::MaskW-1:0] wmask_i,
  input  logic                    q_valid_i,
  output logic                    q_pop_o,
  input  sht_pkg::sht_cmd_t       q_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sht_pkg::sht_rsp_t       out_data_o
);
  import sht_pkg::*;

  localparam int unsigned NumLayers = (MAX_LAYERS < (1 << LayerW)) ? MAX_LAYERS
                                                                   : (1 << LayerW);
  localparam int unsigned Depth = NumLayers * (1 << MipW);
  localparam int unsigned AddrW = $clog2(Depth);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StBase = 2'd1;
  localparam logic [1:0] StWalk = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  function automatic logic [AddrW-1:0] ent_addr(logic [LayerW-1:0] l, logic [MipW-1:0] m);
    return AddrW'({l, m});
  endfunction

  sht_entry_t        mem [Depth];
  logic [Depth-1:0]  vld_q;

  logic [1:0]        st_q;
  sht_cmd_t          cmd_q;
  logic              hazard_q;
  sht_entry_t        prior_q;
  logic [LayerW-1:0] cur_l_q;
  logic [MipW-1:0]   cur_m_q;
  logic              more_q;
  logic              wr_pend_q;
  logic [AddrW-1:0]  wr_addr_q;
  sht_entry_t        rd_data_q;
  logic              rd_vld_q;
  logic              out_valid_q;
  sht_rsp_t          out_q;

  logic [AddrW-1:0]  rd_addr;
  sht_entry_t        base, old, wr_entry;
  logic              hazard, mem_we, out_load, issue;

  always_comb begin
    case (st_q)
      StIdle:  rd_addr = ent_addr(q_data_i.first_layer, q_data_i.first_mip);
      default: rd_addr = ent_addr(cur_l_q, cur_m_q);
    endcase
  end

  // Unwritten entries read as the reset value.
  assign old    = rd_vld_q ? rd_data_q : '0;
  assign base   = cmd_q.base_in ? old : '0;
  assign hazard = (base.layout != cmd_q.target_layout) ||
                  ((base.access & wmask_i) != '0) ||
                  ((cmd_q.dest_access & wmask_i) != '0);

  always_comb begin
    if (hazard_q) begin
      wr_entry.layout = cmd_q.target_layout;
      wr_entry.stage  = cmd_q.dest_stage;
      wr_entry.access = cmd_q.dest_access;
    end else begin
      wr_entry.layout = old.layout;
      wr_entry.stage  = old.stage | cmd_q.dest_stage;
      wr_entry.access = old.access | cmd_q.dest_access;
    end
  end

  assign q_pop_o  = (st_q == StIdle) && q_valid_i;
  assign issue    = (st_q == StWalk) && more_q;
  assign mem_we   = (st_q == StWalk) && wr_pend_q;
  assign out_load = (st_q == StFin) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      more_q      <= 1'b0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      if (mem_we) begin
        vld_q[wr_addr_q] <= 1'b1;
      end
      wr_pend_q <= issue;
      case (st_q)
        StIdle: begin
          if (q_valid_i) begin
            st_q <= StBase;
          end
        end
        StBase: begin
          more_q <= !cmd_q.empty;
          st_q   <= cmd_q.empty ? StFin : StWalk;
        end
        StWalk: begin
          if (issue) begin
            if ((cur_m_q == cmd_q.last_mip) && (cur_l_q == cmd_q.last_layer)) begin
              more_q <= 1'b0;
            end
          end else begin
            st_q <= StFin;
          end
        end
        StFin: begin
          if (out_load) begin
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload, decision, walk pointers and result register.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_data_i;
    end
    if (st_q == StBase) begin
      hazard_q <= hazard;
      prior_q  <= base;
      cur_l_q  <= cmd_q.first_layer;
      cur_m_q  <= cmd_q.first_mip;
    end
    if (issue) begin
      wr_addr_q <= rd_addr;
      if (cur_m_q == cmd_q.last_mip) begin
        cur_m_q <= cmd_q.first_mip;
        cur_l_q <= cur_l_q + LayerW'(1);
      end else begin
        cur_m_q <= cur_m_q + MipW'(1);
      end
    end
    if (out_load) begin
      out_q.barrier_needed <= hazard_q;
      out_q.prior_layout   <= prior_q.layout;
      out_q.prior_stage    <= prior_q.stage;
      out_q.prior_access   <= prior_q.access;
      out_q.range_clipped  <= cmd_q.clipped;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr_q] <= wr_entry;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_wr_in_walk, clk_i, rst_ni, wr_pend_q |-> (st_q == StWalk))
  `ASSERT_ALWAYS(a_fin_to_out, clk_i, rst_ni, out_load |=> out_valid_q)

endmodule

// ===== rtl/subresource_hazard_tracker_top.sv =====
`timescale 1ns / 1ps
// Subresource hazard tracker for one image. The block keeps a table with one
// entry per (layer, mip) holding a layout code, a stage mask and an access
// mask, all zero after reset. Each request names a target layout, destination
// stage and access, and a layer/mip range. The entry at the range base decides:
// a layout change, or a write bit (per write_access_mask, register 0 at byte
// address 0) in the stored or the destination access, means a barrier; then
// every entry of the range is overwritten. Otherwise stage and access are ORed
// into the range. Each request returns exactly one result carrying the base
// entry's prior contents, the barrier flag and a flag for a range clipped at
// the table edge. A front stage classifies and clips the range and feeds a
// two-deep queue; the back stage walks the range as a read-modify-write over
// the single read and single write port of the table memory. Entries start
// valid-cleared on reset, so no clearing pass runs. Results wait in an output
// register, so new requests keep queueing meanwhile.
module subresource_hazard_tracker_top #(
  parameter int unsigned MAX_LAYERS = 8,
  parameter int unsigned MAX_MIPS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sht_pkg::sht_req_t in_data_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sht_pkg::sht_rsp_t out_data_o,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import sht_pkg::*;

  // Register index decoded from the word address bit.
  localparam logic RegWriteMask = 1'b0;

  logic [MaskW-1:0] wmask_q;
  logic             cfg_we;

  sht_cmd_t  push_cmd, pop_cmd;
  logic      q_push, q_full, q_valid, q_pop;

  // Transfer completes in the access phase; pready is tied high.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == RegWriteMask);
  assign prdata = (paddr[2] == RegWriteMask) ? wmask_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wmask_q <= WriteMaskReset;
    end else if (cfg_we) begin
      wmask_q <= pwdata;
    end
  end

  // Classify the request and clip its range.
  sht_front #(
    .MAX_LAYERS (MAX_LAYERS),
    .MAX_MIPS   (MAX_MIPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (push_cmd)
  );

  // Decouple classifier from walker.
  sht_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .full_o      (q_full),
    .push_data_i (push_cmd),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (pop_cmd)
  );

  // Read the base entry, decide, walk the range and report.
  sht_back #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wmask_i     (wmask_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
